@@ rtl/edns_tlv_pkg.sv @@
// Shared types and constants for the EDNS option TLV scanner.
package edns_tlv_pkg;

	// Depth of the queue between the front and the back
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = 2;
	localparam int unsigned Q_CW    = Q_AW + 1;

	// Reset value of the searched option code (name server identifier)
	localparam logic [15:0] TARGET_RESET = 16'd3;

	// Item classes the front puts into the queue
	localparam logic [1:0] KIND_BYTE      = 2'd0;  // byte, record continues
	localparam logic [1:0] KIND_LAST_BYTE = 2'd1;  // byte that ends the record
	localparam logic [1:0] KIND_END       = 2'd2;  // end of record, no byte

	// Header byte positions inside one option
	localparam logic [1:0] HDR_CODE_HI = 2'd0;
	localparam logic [1:0] HDR_LEN_HI  = 2'd2;
	localparam logic [1:0] HDR_LEN_LO  = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
	} q_item_t;

	// Head of the queue as seen by the back
	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

	// Queue status for the top level
	typedef struct packed {
		logic [Q_CW-1:0] count;
	} q_status_t;

	function automatic logic kind_ends(input logic [1:0] kind);
		kind_ends = (kind == KIND_LAST_BYTE) || (kind == KIND_END);
	endfunction

endpackage

@@ rtl/edns_tlv_front.sv @@
// Front part: accepts input beats, classifies them and queues them for the back.
module edns_tlv_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             data_byte,
	input  logic                   byte_valid,
	input  logic                   last,
	output edns_tlv_pkg::q_head_t  head,
	input  logic                   take,
	output edns_tlv_pkg::q_status_t status
);
	import edns_tlv_pkg::*;

	q_item_t         mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic            accept;
	logic            keep;
	logic            wr_en;
	logic            rd_en;
	q_item_t         new_item;

	// Classify: a beat with no byte that does not end the record is dropped
	always_comb begin
		new_item.data_byte = data_byte;
		priority if (byte_valid && last) begin
			new_item.kind = KIND_LAST_BYTE;
		end else if (byte_valid) begin
			new_item.kind = KIND_BYTE;
		end else begin
			new_item.kind = KIND_END;
		end
		keep = byte_valid || last;
	end

	assign full   = (count_q == Q_CW'(Q_DEPTH));
	assign accept = push && !full;
	assign wr_en  = accept && keep;
	assign rd_en  = take && (count_q != '0);

	// Queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid   = (count_q != '0);
	assign head.item    = mem_q[rd_ptr_q];
	assign status.count = count_q;

endmodule

@@ rtl/edns_tlv_back.sv @@
// Back part: walks the option list byte by byte and holds the finished result.
module edns_tlv_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  edns_tlv_pkg::q_head_t head,
	output logic                  take,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	output logic                  empty,
	input  logic                  pop,
	output logic                  found,
	output logic [15:0]           found_offset,
	output logic                  well_formed
);
	import edns_tlv_pkg::*;

	logic [15:0] target_q;
	logic [15:0] offset_q;
	logic [1:0]  hidx_q;
	logic [15:0] opt_start_q;
	logic [15:0] code_q;
	logic [15:0] len_q;
	logic [15:0] left_q;
	logic        match_q;
	logic [15:0] match_off_q;
	logic        res_valid_q;
	logic        res_found_q;
	logic [15:0] res_off_q;
	logic        res_wf_q;

	logic [15:0] offset_d;
	logic [1:0]  hidx_d;
	logic [15:0] opt_start_d;
	logic [15:0] code_d;
	logic [15:0] len_d;
	logic [15:0] left_d;
	logic        match_d;
	logic [15:0] match_off_d;
	logic        has_byte;
	logic        ends;
	logic        slot_free;

	// Take a beat unless it ends a record while the result slot is still full
	assign has_byte  = (head.item.kind == KIND_BYTE) || (head.item.kind == KIND_LAST_BYTE);
	assign ends      = kind_ends(head.item.kind);
	assign slot_free = !res_valid_q || pop;
	assign take      = head.valid && (!ends || slot_free);

	// Next walk state for one byte
	always_comb begin
		offset_d    = offset_q;
		hidx_d      = hidx_q;
		opt_start_d = opt_start_q;
		code_d      = code_q;
		len_d       = len_q;
		left_d      = left_q;
		match_d     = match_q;
		match_off_d = match_off_q;
		if (has_byte) begin
			offset_d = offset_q + 16'd1;
			if (left_q != '0) begin
				left_d = left_q - 16'd1;
			end else begin
				if (hidx_q == HDR_CODE_HI) begin
					opt_start_d = offset_q;
				end
				if (hidx_q < HDR_LEN_HI) begin
					code_d = {code_q[7:0], head.item.data_byte};
				end else begin
					len_d = {len_q[7:0], head.item.data_byte};
				end
				if (hidx_q == HDR_LEN_LO) begin
					// Header complete: code is final, length just assembled
					if (!match_q && (code_q == target_q)) begin
						match_d     = 1'b1;
						match_off_d = opt_start_q;
					end
					left_d = len_d;
					hidx_d = HDR_CODE_HI;
				end else begin
					hidx_d = hidx_q + 2'd1;
				end
			end
		end
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	// Walk state; cleared at the end of each record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			hidx_q      <= HDR_CODE_HI;
			opt_start_q <= '0;
			code_q      <= '0;
			len_q       <= '0;
			left_q      <= '0;
			match_q     <= 1'b0;
			match_off_q <= '0;
		end else if (take) begin
			if (ends) begin
				offset_q    <= '0;
				hidx_q      <= HDR_CODE_HI;
				opt_start_q <= '0;
				code_q      <= '0;
				len_q       <= '0;
				left_q      <= '0;
				match_q     <= 1'b0;
				match_off_q <= '0;
			end else begin
				offset_q    <= offset_d;
				hidx_q      <= hidx_d;
				opt_start_q <= opt_start_d;
				code_q      <= code_d;
				len_q       <= len_d;
				left_q      <= left_d;
				match_q     <= match_d;
				match_off_q <= match_off_d;
			end
		end
	end

	// Result slot valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && ends) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take && ends) begin
			res_found_q <= match_d;
			res_off_q   <= match_d ? match_off_d : 16'd0;
			res_wf_q    <= (hidx_d == HDR_CODE_HI) && (left_d == '0);
		end
	end

	assign empty        = !res_valid_q;
	assign found        = res_found_q;
	assign found_offset = res_off_q;
	assign well_formed  = res_wf_q;

endmodule

@@ rtl/edns_option_tlv_scanner_unit.sv @@
// Top level of the EDNS option TLV scanner: front, queue and back joined.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------
//  input     | push / full        | data_byte, byte_valid, last
//  result    | empty / pop        | found, found_offset, well_formed
//  config    | cfg_we             | cfg_wdata (target option code)
//
// One input beat per cycle while full is low; a beat waits in the queue registers until the back takes it.
// The result of a record shows in the cycle after its last beat is walked.
// A four-entry queue parts front and back; full rises only when it is full.
// The one-entry result slot holds a record end while a result waits unpopped.
// arst_n clears all control state at once; the target code resets to 3.
module edns_option_tlv_scanner_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        empty,
	input  logic        pop,
	output logic        found,
	output logic [15:0] found_offset,
	output logic        well_formed
);
	import edns_tlv_pkg::*;

	q_head_t   head;
	q_status_t status;
	logic      take;

	// Front: classify and queue
	edns_tlv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.head       (head),
		.take       (take),
		.status     (status)
	);

	// Back: option walk and result slot
	edns_tlv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.take         (take),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.empty        (empty),
		.pop          (pop),
		.found        (found),
		.found_offset (found_offset),
		.well_formed  (well_formed)
	);

`ifndef NO_ASSERTIONS
	// Queue head is valid exactly when the fill count is nonzero
	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid == (status.count != '0))
		else $error("queue head valid disagrees with fill count");

	// A record end is never walked while an unpopped result waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop && take) |-> !kind_ends(head.item.kind))
		else $error("result slot overwritten");

	// A popped result leaves the slot empty unless a new record ends
	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !(take && kind_ends(head.item.kind))) |=> empty)
		else $error("result slot not freed after pop");

	// Nothing is taken from an empty queue
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(status.count == '0) |-> !take || !head.valid)
		else $error("take from empty queue");
`endif

endmodule

@@ test/tb.sv @@
// Testbench for the EDNS option TLV scanner: byte stimulus, record summary prediction, checks.
module tb;
	import edns_tlv_pkg::*;

	localparam int QUIET_LIMIT = 5000;   // cycles with no beat moving on either side
	localparam int SETTLE_CYCLES = 12;   // queue, walker and result slot drained
	localparam int HOLD_CYCLES = 300;    // long receiver hold-off

	// Summary of one record as the block reports it
	typedef struct {
		bit        found;
		bit [15:0] offset;
		bit        wf;
	} tlv_summary_t;

	// Walks the option list beside the block and keeps the summaries still owed
	class opt_summary_board;
		bit [15:0]    target = TARGET_RESET;
		bit [15:0]    byte_off;
		bit [1:0]     hdr_pos;
		bit [15:0]    opt_start;
		bit [15:0]    code_acc;
		bit [15:0]    len_acc;
		bit [15:0]    payload_left;
		bit           match_seen;
		bit [15:0]    match_off;
		tlv_summary_t summaries_due[$];
		int           errors;

		function void clear_walk();
			byte_off = 0;
			hdr_pos = HDR_CODE_HI;
			opt_start = 0;
			code_acc = 0;
			len_acc = 0;
			payload_left = 0;
			match_seen = 0;
			match_off = 0;
		endfunction

		function void walk_byte(bit [7:0] b);
			if (payload_left != 0) begin
				payload_left--;
			end else begin
				if (hdr_pos == HDR_CODE_HI)
					opt_start = byte_off;
				if (hdr_pos < HDR_LEN_HI)
					code_acc = {code_acc[7:0], b};
				else
					len_acc = {len_acc[7:0], b};
				// header complete: compare against the code in force right now
				if (hdr_pos == HDR_LEN_LO) begin
					if (!match_seen && code_acc == target) begin
						match_seen = 1;
						match_off = opt_start;
					end
					payload_left = len_acc;
					hdr_pos = HDR_CODE_HI;
				end else begin
					hdr_pos++;
				end
			end
			byte_off++;
		endfunction

		// accepted input beat
		function void note_beat(bit [7:0] b, bit v, bit l);
			tlv_summary_t s;
			if (v)
				walk_byte(b);
			if (l) begin
				s.found = match_seen;
				s.offset = match_seen ? match_off : 16'd0;
				s.wf = (hdr_pos == HDR_CODE_HI) && (payload_left == 0);
				summaries_due.push_back(s);
				clear_walk();
			end
		endfunction

		// accepted result beat
		function void check_summary(logic f, logic [15:0] off, logic wf);
			tlv_summary_t want;
			if (summaries_due.size() == 0) begin
				$display("%0t: unexpected result found=%0d found_offset=%0d well_formed=%0d",
					$time, f, off, wf);
				errors++;
				return;
			end
			want = summaries_due.pop_front();
			if (f !== want.found) begin
				$display("%0t: found mismatch, expected %0d, got %0d", $time, want.found, f);
				errors++;
			end
			if (off !== want.offset) begin
				$display("%0t: found_offset mismatch, expected %0d, got %0d",
					$time, want.offset, off);
				errors++;
			end
			if (wf !== want.wf) begin
				$display("%0t: well_formed mismatch, expected %0d, got %0d", $time, want.wf, wf);
				errors++;
			end
		endfunction

		function int pending();
			return summaries_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_valid = 1'b0;
	logic        last = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;
	logic        empty;
	logic        pop = 1'b0;
	logic        found;
	logic [15:0] found_offset;
	logic        well_formed;

	opt_summary_board board = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int noise_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit hold_req = 0;

	edns_option_tlv_scanner_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.empty        (empty),
		.pop          (pop),
		.found        (found),
		.found_offset (found_offset),
		.well_formed  (well_formed)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Offer one beat, with random idle cycles ahead of it, until it is taken
	task automatic send_beat(input bit [7:0] b, input bit v, input bit l);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		byte_valid <= v;
		last <= l;
		do @(posedge clk); while (full);
		board.note_beat(b, v, l);
		if (v || l)
			items_sent++;
	endtask

	// Byte run, optionally closed by last on its final byte; ignored beats mixed in
	task automatic send_run(input bit [7:0] rec[$], input bit mark_last);
		for (int i = 0; i < rec.size(); i++) begin
			if ($urandom_range(99) < noise_pct)
				send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
			send_beat(rec[i], 1'b1, mark_last && (i == rec.size() - 1));
		end
	endtask

	// Sender pauses until every summary is in, then lets the pipeline settle
	task automatic wait_results_done();
		push <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_target(input bit [15:0] code);
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.target = code;
	endtask

	// One record: mostly a clean option list, sometimes empty, cut, padded or overrunning
	task automatic send_random_record();
		bit [7:0]  rec[$];
		bit [15:0] code;
		bit [15:0] plen;
		int        n_opt;
		if ($urandom_range(99) < 8) begin
			send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
			return;
		end
		n_opt = $urandom_range(1, 3);
		for (int i = 0; i < n_opt; i++) begin
			if ($urandom_range(99) < 35)
				code = board.target;
			else if ($urandom_range(1) != 0)
				code = 16'($urandom_range(7));
			else
				code = 16'($urandom_range(16'hFFFF));
			plen = ($urandom_range(9) == 0) ? 16'($urandom_range(6, 40))
				: 16'($urandom_range(5));
			rec.push_back(code[15:8]);
			rec.push_back(code[7:0]);
			rec.push_back(plen[15:8]);
			rec.push_back(plen[7:0]);
			repeat (plen) rec.push_back(8'($urandom_range(255)));
		end
		case ($urandom_range(9))
			0: begin
				// truncated inside an option
				repeat ($urandom_range(1, rec.size() - 1)) rec.delete(rec.size() - 1);
			end
			1: begin
				// partial header trailing
				repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom_range(255)));
			end
			2: begin
				// option whose payload runs past the end
				code = ($urandom_range(1) != 0) ? board.target
					: 16'($urandom_range(16'hFFFF));
				plen = 16'($urandom_range(1, 16'hFFFF));
				rec.push_back(code[15:8]);
				rec.push_back(code[7:0]);
				rec.push_back(plen[15:8]);
				rec.push_back(plen[7:0]);
			end
			default: ;
		endcase
		if ($urandom_range(9) < 7) begin
			send_run(rec, 1'b1);
		end else begin
			send_run(rec, 1'b0);
			send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
		end
	endtask

	// Receiver: check each popped beat, then choose pop for the next edge
	initial begin
		forever begin
			@(posedge clk);
			if (pop && !empty)
				board.check_summary(found, found_offset, well_formed);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int        phase_send[4];
		int        phase_stall[4];
		bit [15:0] phase_target[4];
		int        quota;
		bit        hold_done;
		phase_send = '{0, 87, 0, 20};
		phase_stall = '{0, 0, 87, 20};
		phase_target = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0003};
		phase_target[2] = 16'($urandom_range(16'hFFFF));
		hold_done = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed records under the reset target code
		send_beat(8'hA5, 1'b0, 1'b1);
		send_beat(8'hFF, 1'b0, 1'b0);
		send_run('{8'h00, 8'h03, 8'h00, 8'h00}, 1'b1);
		send_run('{8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF}, 1'b1);
		send_run('{8'h00, 8'h03, 8'hFF, 8'hFF, 8'h00}, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		send_run('{8'h00, 8'h03, 8'h00}, 1'b1);
		send_run('{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00}, 1'b1);

		// target changed between the code and length bytes of one option
		send_run('{8'h00, 8'h07}, 1'b0);
		wait_results_done();
		set_target(16'h0007);
		send_run('{8'h00, 8'h00}, 1'b1);

		// random phases with different idle patterns and target codes
		for (int ph = 0; ph < 4; ph++) begin
			wait_results_done();
			set_target(phase_target[ph]);
			send_idle_pct = phase_send[ph];
			recv_stall_pct = phase_stall[ph];
			noise_pct = 4;
			quota = items_sent + 175;
			while (items_sent < quota) begin
				if (ph == 0 && !hold_done && items_sent >= quota - 120) begin
					hold_req = 1;
					hold_done = 1;
				end
				send_random_record();
			end
		end

		wait_results_done();
		if (board.errors == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
